[rtl/core/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg: shared definitions for the sorted priority list
// Action and status codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 8;
	localparam int TAG_BITS_DEF = 16;

	localparam int ACTION_W   = 2;
	localparam int POSITION_W = 6;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BEYOND    = 2'd3;

	// Update command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins_en;
		logic rem_en;
	} spl_cmd_t;

endpackage

[rtl/core/spl_prefix_or.sv]
// ----------------------------------------------------------------------------
// spl_prefix_or: inclusive prefix OR
// Log-depth prefix network; bit i of the result is the OR of bits 0 to i.
// ----------------------------------------------------------------------------
module spl_prefix_or #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0] bits,
	output logic [WIDTH-1:0] prefix
);

	localparam int LEVELS = $clog2(WIDTH);

	logic [WIDTH-1:0] lvl [0:LEVELS];

	assign lvl[0] = bits;

	for (genvar s = 0; s < LEVELS; s++) begin : g_level
		for (genvar i = 0; i < WIDTH; i++) begin : g_bit
			if (i >= (1 << s)) begin : g_merge
				assign lvl[s+1][i] = lvl[s][i] | lvl[s][i - (1 << s)];
			end else begin : g_pass
				assign lvl[s+1][i] = lvl[s][i];
			end
		end
	end

	assign prefix = lvl[LEVELS];

endmodule

[rtl/core/spl_cell.sv]
// ----------------------------------------------------------------------------
// spl_cell: one list slot
// Holds one tag and key, compares them against the request, and on an
// update keeps its entry, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spl_cell #(
	parameter int KEY_BITS = 8,
	parameter int TAG_BITS = 16
) (
	input  logic                  clk,
	input  spl_pkg::spl_cmd_t     cmd,
	input  logic                  occupied,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [TAG_BITS-1:0]   tag,
	input  logic                  prev_ge,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [TAG_BITS-1:0]   prev_tag,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [TAG_BITS-1:0]   next_tag,
	input  logic                  removed_upto,
	output logic                  ge,
	output logic                  match,
	output logic [KEY_BITS-1:0]   cell_key,
	output logic [TAG_BITS-1:0]   cell_tag
);

	import spl_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;

	assign ge    = occupied && (key_q >= key);
	assign match = occupied && (tag_q == tag);

	// Cells ahead of the insertion point keep their entry; the first cell
	// that is not ahead takes the new entry and the rest shift down by one.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !ge) begin
			if (prev_ge) begin
				key_q <= key;
				tag_q <= tag;
			end else begin
				key_q <= prev_key;
				tag_q <= prev_tag;
			end
		end else if (cmd.rem_en && removed_upto) begin
			key_q <= next_key;
			tag_q <= next_tag;
		end
	end

	assign cell_key = key_q;
	assign cell_tag = tag_q;

endmodule

[rtl/core/sorted_priority_list_unit.sv]
// ----------------------------------------------------------------------------
// sorted_priority_list_unit: priority list kept in descending key order
// Insert, remove by tag and read by position over a chain of list cells.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_ready  | action, key, tag, position
//   out     | out_valid / out_ready| status, count, read_tag, read_key
//
// All cells compare and shift in parallel on the accepting edge, and the
// result appears in the output register on the next cycle. A new request
// is accepted while the result register is empty or being drained, so the
// sustained rate is one per cycle. Reset clears the entry count and the
// output valid; cell contents are not reset. A stalled output holds the
// list unchanged until it drains.
// ----------------------------------------------------------------------------
module sorted_priority_list_unit #(
	parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = spl_pkg::TAG_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [spl_pkg::ACTION_W-1:0]   action,
	input  logic [KEY_BITS-1:0]            key,
	input  logic [TAG_BITS-1:0]            tag,
	input  logic [spl_pkg::POSITION_W-1:0] position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [spl_pkg::STATUS_W-1:0]   status,
	output logic [spl_pkg::COUNT_W-1:0]    count,
	output logic [TAG_BITS-1:0]            read_tag,
	output logic [KEY_BITS-1:0]            read_key
);

	import spl_pkg::*;

	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int IDX_BITS = $clog2(CAPACITY);
	localparam int CMP_W    = (CNT_BITS > POSITION_W) ? CNT_BITS : POSITION_W;

	logic [CNT_BITS-1:0] count_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic [TAG_BITS-1:0] read_tag_q;
	logic [KEY_BITS-1:0] read_key_q;

	logic                accept;
	logic                full;
	logic                found;
	logic                pos_ok;
	logic [CMP_W-1:0]    pos_ext;
	logic [IDX_BITS-1:0] rd_idx;
	logic [CNT_BITS-1:0] count_nxt;
	logic [STATUS_W-1:0] status_nxt;
	logic [TAG_BITS-1:0] rtag_nxt;
	logic [KEY_BITS-1:0] rkey_nxt;
	spl_cmd_t            cmd;

	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] ge_vec;
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] seen_vec;
	logic [KEY_BITS-1:0] cell_key [CAPACITY];
	logic [TAG_BITS-1:0] cell_tag [CAPACITY];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_BITS'(CAPACITY));
	assign found    = seen_vec[CAPACITY-1];

	assign cmd.ins_en = accept && (action == ACT_INSERT) && !full;
	assign cmd.rem_en = accept && (action == ACT_REMOVE) && found;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                prev_ge;
		logic [KEY_BITS-1:0] prev_key;
		logic [TAG_BITS-1:0] prev_tag;
		logic [KEY_BITS-1:0] next_key;
		logic [TAG_BITS-1:0] next_tag;

		assign occ[i] = (CNT_BITS'(i) < count_q);

		// The head cell sees an always-ahead neighbor; the tail shifts in itself.
		if (i == 0) begin : g_head
			assign prev_ge  = 1'b1;
			assign prev_key = key;
			assign prev_tag = tag;
		end else begin : g_body
			assign prev_ge  = ge_vec[i-1];
			assign prev_key = cell_key[i-1];
			assign prev_tag = cell_tag[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_key = cell_key[i];
			assign next_tag = cell_tag[i];
		end else begin : g_inner
			assign next_key = cell_key[i+1];
			assign next_tag = cell_tag[i+1];
		end

		spl_cell #(
			.KEY_BITS(KEY_BITS),
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occ[i]),
			.key         (key),
			.tag         (tag),
			.prev_ge     (prev_ge),
			.prev_key    (prev_key),
			.prev_tag    (prev_tag),
			.next_key    (next_key),
			.next_tag    (next_tag),
			.removed_upto(seen_vec[i]),
			.ge          (ge_vec[i]),
			.match       (match_vec[i]),
			.cell_key    (cell_key[i]),
			.cell_tag    (cell_tag[i])
		);
	end

	// A cell closes the gap when the first matching tag sits at or above it.
	spl_prefix_or #(
		.WIDTH(CAPACITY)
	) u_prefix (
		.bits  (match_vec),
		.prefix(seen_vec)
	);

	assign pos_ext = CMP_W'(position);
	assign pos_ok  = (pos_ext < CMP_W'(count_q));
	assign rd_idx  = pos_ext[IDX_BITS-1:0];

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		rtag_nxt   = '0;
		rkey_nxt   = '0;
		case (action)
			ACT_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (found) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = ST_NOT_FOUND;
				end
			end
			ACT_READ: begin
				if (pos_ok) begin
					rtag_nxt = cell_tag[rd_idx];
					rkey_nxt = cell_key[rd_idx];
				end else begin
					status_nxt = ST_BEYOND;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			count_out_q <= COUNT_W'(count_nxt);
			read_tag_q  <= rtag_nxt;
			read_key_q  <= rkey_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_out_q;
	assign read_tag  = read_tag_q;
	assign read_key  = read_key_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ACT_INSERT) && full |=>
			out_valid && (status == ST_FULL) && (count_q == CNT_BITS'(CAPACITY)))
		else $error("insert into a full list was not dropped");

	a_remove_miss: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ACT_REMOVE) && !found |=>
			(status == ST_NOT_FOUND) && $stable(count_q))
		else $error("remove of an absent tag changed the list");

	a_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BEYOND) |-> (read_tag == '0) && (read_key == '0))
		else $error("read beyond count returned data");

endmodule

[bench/sorted_priority_list_unit_tb.sv]
// ----------------------------------------------------------------------------
// sorted_priority_list_unit_tb: self-checking bench for the priority list
// Drives insert, remove, read and unused requests through a valid/ready
// channel with random bursts and output stalls. A shadow copy of the list
// predicts each result, and every result is checked in order against it.
// ----------------------------------------------------------------------------
module sorted_priority_list_unit_tb;
	import spl_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int KEY_W = KEY_BITS_DEF;
	localparam int TAG_W = TAG_BITS_DEF;
	localparam int RANDOM_REQUESTS = 530;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 10;
	localparam int MAX_REPORTS = 10;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [KEY_W-1:0]      key;
		logic [TAG_W-1:0]      tag;
		logic [POSITION_W-1:0] position;
	} list_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [TAG_W-1:0]    rtag;
		logic [KEY_W-1:0]    rkey;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ACTION_W-1:0] action = '0;
	logic [KEY_W-1:0] key = '0;
	logic [TAG_W-1:0] tag = '0;
	logic [POSITION_W-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0] count;
	logic [TAG_W-1:0] read_tag;
	logic [KEY_W-1:0] read_key;

	// Shadow of the list contents used to predict each result.
	logic [TAG_W-1:0] shadow_tag [CAPACITY];
	logic [KEY_W-1:0] shadow_key [CAPACITY];
	int shadow_count = 0;

	// Tags that the generator believes are live, so removes can hit.
	logic [TAG_W-1:0] live_tags [$];

	list_req_t pending_requests [$];
	list_result_t due_results [$];

	bit req_fire = 1'b0;
	int quiet_cycles = 0;
	int error_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int ready_left = 0;
	int stall_left = 0;

	sorted_priority_list_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.key      (key),
		.tag      (tag),
		.position (position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.count    (count),
		.read_tag (read_tag),
		.read_key (read_key)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_result_t apply_to_list(list_req_t r);
		list_result_t res;
		int slot;
		int i;
		res.status = ST_OK;
		res.rtag = '0;
		res.rkey = '0;
		case (r.action)
			ACT_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					// New entry goes behind every entry of greater or equal key.
					slot = 0;
					while (slot < shadow_count && shadow_key[slot] >= r.key)
						slot++;
					for (i = shadow_count; i > slot; i--) begin
						shadow_tag[i] = shadow_tag[i-1];
						shadow_key[i] = shadow_key[i-1];
					end
					shadow_tag[slot] = r.tag;
					shadow_key[slot] = r.key;
					shadow_count++;
				end
			end
			ACT_REMOVE: begin
				slot = 0;
				while (slot < shadow_count && shadow_tag[slot] != r.tag)
					slot++;
				if (slot >= shadow_count) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (i = slot + 1; i < shadow_count; i++) begin
						shadow_tag[i-1] = shadow_tag[i];
						shadow_key[i-1] = shadow_key[i];
					end
					shadow_count--;
				end
			end
			ACT_READ: begin
				if (int'(r.position) < shadow_count) begin
					res.rtag = shadow_tag[r.position];
					res.rkey = shadow_key[r.position];
				end else begin
					res.status = ST_BEYOND;
				end
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(shadow_count);
		return res;
	endfunction

	// Queues a request and tracks which tags it leaves in the list.
	task automatic queue_request(logic [ACTION_W-1:0] a, logic [KEY_W-1:0] k,
			logic [TAG_W-1:0] t, logic [POSITION_W-1:0] p);
		list_req_t r;
		int i;
		r.action = a;
		r.key = k;
		r.tag = t;
		r.position = p;
		pending_requests.push_back(r);
		if (a == ACT_INSERT && live_tags.size() < CAPACITY) begin
			live_tags.push_back(t);
		end else if (a == ACT_REMOVE) begin
			for (i = 0; i < live_tags.size(); i++) begin
				if (live_tags[i] == t) begin
					live_tags.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Request and result handshakes are both observed on the rising edge.
	always @(posedge clk) begin
		list_result_t got;
		list_result_t want;
		list_req_t r;
		req_fire = arst_n && in_valid && in_ready;
		if (req_fire) begin
			r.action = action;
			r.key = key;
			r.tag = tag;
			r.position = position;
			due_results.push_back(apply_to_list(r));
		end
		if (arst_n && out_valid && out_ready) begin
			got.status = status;
			got.count = count;
			got.rtag = read_tag;
			got.rkey = read_key;
			if (due_results.size() == 0) begin
				flag_error($sformatf("result with no request waiting: status=%0d count=%0d",
					got.status, got.count));
			end else begin
				want = due_results.pop_front();
				if (got.status !== want.status || got.count !== want.count ||
						got.rtag !== want.rtag || got.rkey !== want.rkey)
					flag_error($sformatf({"mismatch: expected status=%0d count=%0d tag=%h ",
						"key=%h, got status=%0d count=%0d tag=%h key=%h"},
						want.status, want.count, want.rtag, want.rkey,
						got.status, got.count, got.rtag, got.rkey));
			end
		end
		if (req_fire || (arst_n && out_valid && out_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
	end

	// Request driver: bursts of back-to-back requests separated by random gaps.
	always @(negedge clk) begin
		list_req_t r;
		if (arst_n && !(in_valid && !req_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				r = pending_requests.pop_front();
				action <= r.action;
				key <= r.key;
				tag <= r.tag;
				position <= r.position;
				in_valid <= 1'b1;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side: runs of ready cycles broken by short stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_left > 0) begin
				ready_left--;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				ready_left = $urandom_range(1, 40);
				stall_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int n;
		int roll;
		bit filling;
		logic [ACTION_W-1:0] a;
		logic [KEY_W-1:0] k;
		logic [TAG_W-1:0] t;
		logic [POSITION_W-1:0] p;

		// Empty list corner cases, then ties at both key extremes.
		queue_request(ACT_READ, 8'h00, 16'h0000, 6'd0);
		queue_request(ACT_REMOVE, 8'hFF, 16'h1234, 6'd63);
		queue_request(ACT_UNUSED, 8'hFF, 16'hFFFF, 6'd63);
		queue_request(ACT_INSERT, 8'h00, 16'h0000, 6'd0);
		queue_request(ACT_INSERT, 8'hFF, 16'hFFFF, 6'd63);
		queue_request(ACT_INSERT, 8'h80, 16'hAAAA, 6'd0);
		queue_request(ACT_INSERT, 8'h80, 16'h5555, 6'd0);
		queue_request(ACT_INSERT, 8'h00, 16'h0001, 6'd0);
		queue_request(ACT_INSERT, 8'hFF, 16'hFFFF, 6'd0);
		for (n = 0; n < 6; n++)
			queue_request(ACT_READ, 8'hFF, 16'hFFFF, POSITION_W'(n));
		queue_request(ACT_READ, 8'h00, 16'h0000, 6'd6);
		queue_request(ACT_READ, 8'h00, 16'h0000, 6'd63);
		// The duplicate tag removes the older of the two entries first.
		queue_request(ACT_REMOVE, 8'h00, 16'hFFFF, 6'd0);
		queue_request(ACT_REMOVE, 8'h00, 16'h0000, 6'd0);
		queue_request(ACT_REMOVE, 8'h00, 16'hBEEF, 6'd0);
		queue_request(ACT_READ, 8'h00, 16'h0000, 6'd0);
		queue_request(ACT_READ, 8'h00, 16'h0000, 6'd2);
		queue_request(ACT_UNUSED, 8'h5A, 16'hC3C3, 6'd21);

		// Random part alternates between filling the list up to full and
		// draining it to empty, so both ends are visited repeatedly.
		filling = 1'b1;
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			roll = $urandom_range(0, 99);
			if (filling)
				a = (roll < 72) ? ACT_INSERT : (roll < 82) ? ACT_REMOVE :
					(roll < 97) ? ACT_READ : ACT_UNUSED;
			else
				a = (roll < 15) ? ACT_INSERT : (roll < 70) ? ACT_REMOVE :
					(roll < 97) ? ACT_READ : ACT_UNUSED;
			case ($urandom_range(0, 3))
				0: k = KEY_W'($urandom_range(0, 3));
				1: k = KEY_W'($urandom_range(252, 255));
				default: k = KEY_W'($urandom_range(0, 255));
			endcase
			if (live_tags.size() > 0 && (a == ACT_REMOVE ? $urandom_range(0, 4) != 0 :
					$urandom_range(0, 6) == 0))
				t = live_tags[$urandom_range(0, live_tags.size() - 1)];
			else
				t = TAG_W'($urandom);
			if (live_tags.size() > 0 && $urandom_range(0, 4) != 0)
				p = POSITION_W'($urandom_range(0, live_tags.size() - 1));
			else
				p = POSITION_W'($urandom_range(0, 63));
			queue_request(a, k, t, p);
			if (filling && live_tags.size() == CAPACITY && $urandom_range(0, 5) == 0)
				filling = 1'b0;
			else if (!filling && live_tags.size() == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do begin
			@(posedge clk);
			#1;
		end while (!(pending_requests.size() == 0 && !in_valid && due_results.size() == 0)
			&& quiet_cycles < WATCHDOG_LIMIT);

		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			#1;
			if (error_count == 0)
				$display("ALL CHECKS PASSED");
			else
				$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
